>>> rtl/htbd_pkg.sv
// ============================================================================
// htbd_pkg
// Shared types and constants for the Huffman tree-walk bit decoder.
// ============================================================================
package htbd_pkg;

   localparam int NODE_COUNT_DEFAULT = 512;

   localparam int INDEX_W = 9;
   localparam int SYM_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 4;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   localparam logic [COUNT_W-1:0] FULL_BITS = COUNT_W'(8);

   // fixed-point scale of the reciprocal used for index reduction
   localparam int WRAP_SHIFT = 18;

   typedef enum logic [0:0] {
      OP_WRITE_NODE = 1'b0,
      OP_DECODE     = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_ROOT_INDEX = 1'b0,
      CSR_UNUSED     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_CUR,
      ST_EVAL_CHILD,
      ST_FLUSH,
      ST_WR_0,
      ST_WR_1,
      ST_WR_2
   } state_type;

endpackage

>>> rtl/htbd_index_wrap.sv
// ============================================================================
// htbd_index_wrap
// Two-stage reduction of a 9-bit index modulo NODE_COUNT by reciprocal
// multiply and one correction step.
// ============================================================================
module htbd_index_wrap #(
   parameter int NODE_COUNT = htbd_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [htbd_pkg::INDEX_W-1:0]  value,
   output logic [$clog2(NODE_COUNT)-1:0] wrapped
);

   localparam int IDX_W   = $clog2(NODE_COUNT);
   localparam int VW      = htbd_pkg::INDEX_W;
   localparam int RW      = VW + 1;
   localparam int RECIP_W = htbd_pkg::WRAP_SHIFT - IDX_W + 1;
   localparam int PROD_W  = VW + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((1 << htbd_pkg::WRAP_SHIFT) / NODE_COUNT);

   logic [VW-1:0]    value_ff, value_in;
   logic [VW-1:0]    quot_ff, quot_in;
   logic [IDX_W-1:0] wrapped_ff, wrapped_in;
   logic [PROD_W-1:0] prod1;
   logic [RW-1:0]    prod2;
   logic [RW-1:0]    diff;
   logic [RW-1:0]    rem;

   always_comb begin
      prod1    = PROD_W'(value) * PROD_W'(RECIP);
      quot_in  = VW'(prod1 >> htbd_pkg::WRAP_SHIFT);
      value_in = value;
   end

   always_comb begin
      prod2 = RW'(quot_ff) * RW'(NODE_COUNT);
      diff  = {1'b0, value_ff} - prod2;
      if (32'(diff) >= 32'(NODE_COUNT)) begin
         rem = diff - RW'(NODE_COUNT);
      end else begin
         rem = diff;
      end
      wrapped_in = IDX_W'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= '0;
         quot_ff    <= '0;
         wrapped_ff <= '0;
      end else begin
         value_ff   <= value_in;
         quot_ff    <= quot_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign wrapped = wrapped_ff;

endmodule

>>> rtl/htbd_node_mem.sv
// ============================================================================
// htbd_node_mem
// Node table: one write port, one read port, registered read data.
// ============================================================================
module htbd_node_mem #(
   parameter int DEPTH  = htbd_pkg::NODE_COUNT_DEFAULT,
   parameter int DATA_W = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/huffman_tree_bit_decoder_core.sv
// ============================================================================
// huffman_tree_bit_decoder_core
// Walks a Huffman tree in node memory, one tree step per cycle unless stalled.
// ============================================================================
// Node write: index wrap in ST_WR_0 and ST_WR_1, then the write in ST_WR_2.
// Decode: accept reads the start node, then one read per bit and one root
//   refetch per symbol, set by the single read port of the node memory;
//   ST_FLUSH closes the byte. Each symbol is held until the next one is
//   found; the last symbol of a byte leaves at the close.
// Reset is synchronous: walk at root, root_index 0, no result pending.
// The node table is not cleared; no clearing pass.
module huffman_tree_bit_decoder_core #(
   parameter int NODE_COUNT = htbd_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [htbd_pkg::INDEX_W-1:0]      req_node_index,
   input  logic                              req_node_is_leaf,
   input  logic [htbd_pkg::INDEX_W-1:0]      req_left_child,
   input  logic [htbd_pkg::INDEX_W-1:0]      req_right_child,
   input  logic [htbd_pkg::SYM_W-1:0]        req_node_symbol,
   input  logic [htbd_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [htbd_pkg::COUNT_W-1:0]      req_bit_count,
   input  logic                              req_end_of_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [htbd_pkg::SYM_W-1:0]        rsp_symbol,
   output logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [htbd_pkg::PADDR_W-1:0]      paddr,
   input  logic [htbd_pkg::CSR_W-1:0]        pwdata,
   output logic [htbd_pkg::CSR_W-1:0]        prdata,
   output logic                              pready
);

   localparam int IDX_W   = $clog2(NODE_COUNT);
   localparam int SYM_W   = htbd_pkg::SYM_W;
   localparam int VW      = htbd_pkg::INDEX_W;
   localparam int CNT_W   = htbd_pkg::COUNT_W;
   localparam int BYTE_W  = htbd_pkg::BYTE_W;
   localparam int ENTRY_W = 1 + 2 * IDX_W + SYM_W;
   localparam int RIGHT_LSB = SYM_W;
   localparam int LEFT_LSB  = SYM_W + IDX_W;

   htbd_pkg::state_type state_ff, state_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]  rsp_symbol_ff, rsp_symbol_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]  pend_sym_ff, pend_sym_in;
   logic              at_root_ff, at_root_in;
   logic [IDX_W-1:0]  walk_node_ff, walk_node_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              eos_ff, eos_in;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [VW-1:0]     root_ff, root_in;
   logic [VW-1:0]     item_index_ff, item_index_in;
   logic              item_leaf_ff, item_leaf_in;
   logic [VW-1:0]     item_left_ff, item_left_in;
   logic [VW-1:0]     item_right_ff, item_right_in;
   logic [SYM_W-1:0]  item_sym_ff, item_sym_in;

   logic               req_accept;
   logic               accept_decode;
   logic               accept_write;
   logic               csr_write;
   logic               out_free;
   logic               emit_ok;
   logic               more_bits;
   logic [CNT_W-1:0]   count_sat;

   logic [ENTRY_W-1:0] rd_data;
   logic               rd_leaf;
   logic [IDX_W-1:0]   rd_left;
   logic [IDX_W-1:0]   rd_right;
   logic [SYM_W-1:0]   rd_sym;

   logic [IDX_W-1:0]   root_wrap;
   logic [IDX_W-1:0]   index_wrap;
   logic [IDX_W-1:0]   left_wrap;
   logic [IDX_W-1:0]   right_wrap;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic               emit;
   logic               consume;
   logic               descend;
   logic               flush_done;
   logic               out_load;

   // ---------------------------------------------------------------- csr
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == htbd_pkg::CSR_ROOT_INDEX);
   assign prdata    = (paddr[2] == htbd_pkg::CSR_ROOT_INDEX)
                      ? {(htbd_pkg::CSR_W - VW)'(0), root_ff} : '0;

   // ---------------------------------------------------------- handshake
   assign req_stall     = (state_ff != htbd_pkg::ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign accept_decode = req_accept && (req_opcode == htbd_pkg::OP_DECODE);
   assign accept_write  = req_accept && (req_opcode == htbd_pkg::OP_WRITE_NODE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign emit_ok       = !pend_valid_ff || out_free;
   assign more_bits     = (rem_ff > CNT_W'(1));
   assign count_sat     = (req_bit_count > htbd_pkg::FULL_BITS)
                          ? htbd_pkg::FULL_BITS : req_bit_count;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // ------------------------------------------------------- node fields
   assign rd_leaf  = rd_data[ENTRY_W-1];
   assign rd_left  = rd_data[LEFT_LSB +: IDX_W];
   assign rd_right = rd_data[RIGHT_LSB +: IDX_W];
   assign rd_sym   = rd_data[SYM_W-1:0];

   htbd_index_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap_root (
      .clock(clock), .reset(reset), .value(root_ff), .wrapped(root_wrap)
   );
   htbd_index_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap_index (
      .clock(clock), .reset(reset), .value(item_index_ff), .wrapped(index_wrap)
   );
   htbd_index_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap_left (
      .clock(clock), .reset(reset), .value(item_left_ff), .wrapped(left_wrap)
   );
   htbd_index_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap_right (
      .clock(clock), .reset(reset), .value(item_right_ff), .wrapped(right_wrap)
   );

   htbd_node_mem #(.DEPTH(NODE_COUNT), .DATA_W(ENTRY_W)) u_node_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (index_wrap),
      .wr_data ({item_leaf_ff, left_wrap, right_wrap, item_sym_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------- fsm outputs
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = walk_node_ff;
      wr_en      = 1'b0;
      emit       = 1'b0;
      consume    = 1'b0;
      descend    = 1'b0;
      flush_done = 1'b0;
      case (state_ff)
         htbd_pkg::ST_IDLE: begin
            if (accept_decode && (count_sat != '0)) begin
               rd_en   = 1'b1;
               rd_addr = at_root_ff ? root_wrap : walk_node_ff;
            end
         end
         htbd_pkg::ST_EVAL_CUR: begin
            if (rd_leaf) begin
               if (emit_ok) begin
                  emit    = 1'b1;
                  consume = 1'b1;
                  rd_en   = more_bits;
                  rd_addr = root_wrap;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = byte_ff[BYTE_W-1] ? rd_right : rd_left;
            end
         end
         htbd_pkg::ST_EVAL_CHILD: begin
            if (rd_leaf) begin
               if (emit_ok) begin
                  emit    = 1'b1;
                  consume = 1'b1;
                  rd_en   = more_bits;
                  rd_addr = root_wrap;
               end
            end else begin
               consume = 1'b1;
               descend = 1'b1;
               rd_en   = more_bits;
               rd_addr = byte_ff[BYTE_W-2] ? rd_right : rd_left;
            end
         end
         htbd_pkg::ST_FLUSH: begin
            flush_done = !pend_valid_ff || out_free;
         end
         htbd_pkg::ST_WR_2: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign out_load = pend_valid_ff && (emit || flush_done);

   // ---------------------------------------------------- fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htbd_pkg::ST_IDLE: begin
            if (accept_write) begin
               state_in = htbd_pkg::ST_WR_0;
            end else if (accept_decode) begin
               state_in = (count_sat == '0) ? htbd_pkg::ST_FLUSH
                                            : htbd_pkg::ST_EVAL_CUR;
            end
         end
         htbd_pkg::ST_EVAL_CUR: begin
            if (!rd_leaf) begin
               state_in = htbd_pkg::ST_EVAL_CHILD;
            end else if (emit_ok) begin
               state_in = more_bits ? htbd_pkg::ST_EVAL_CUR : htbd_pkg::ST_FLUSH;
            end
         end
         htbd_pkg::ST_EVAL_CHILD: begin
            if (!rd_leaf) begin
               state_in = more_bits ? htbd_pkg::ST_EVAL_CHILD : htbd_pkg::ST_FLUSH;
            end else if (emit_ok) begin
               state_in = more_bits ? htbd_pkg::ST_EVAL_CUR : htbd_pkg::ST_FLUSH;
            end
         end
         htbd_pkg::ST_FLUSH: begin
            if (flush_done) begin
               state_in = htbd_pkg::ST_IDLE;
            end
         end
         htbd_pkg::ST_WR_0: state_in = htbd_pkg::ST_WR_1;
         htbd_pkg::ST_WR_1: state_in = htbd_pkg::ST_WR_2;
         htbd_pkg::ST_WR_2: state_in = htbd_pkg::ST_IDLE;
         default:           state_in = htbd_pkg::ST_IDLE;
      endcase
   end

   // --------------------------------------------------------- datapath
   always_comb begin
      rsp_valid_in  = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_symbol_in = out_load ? pend_sym_ff : rsp_symbol_ff;
      rsp_last_in   = out_load ? flush_done : rsp_last_ff;

      // newest symbol waits here until the next one or the byte end
      pend_valid_in = emit ? 1'b1 : (flush_done ? 1'b0 : pend_valid_ff);
      pend_sym_in   = emit ? rd_sym : pend_sym_ff;

      at_root_in   = at_root_ff;
      walk_node_in = walk_node_ff;
      if (emit || (flush_done && eos_ff)) begin
         at_root_in   = 1'b1;
         walk_node_in = '0;
      end else if (descend) begin
         at_root_in   = 1'b0;
         walk_node_in = rd_addr_ff;
      end

      byte_in = byte_ff;
      rem_in  = rem_ff;
      if (accept_decode) begin
         byte_in = req_data_byte;
         rem_in  = count_sat;
      end else if (consume) begin
         byte_in = {byte_ff[BYTE_W-2:0], 1'b0};
         rem_in  = rem_ff - CNT_W'(1);
      end

      eos_in     = req_accept ? req_end_of_stream : eos_ff;
      rd_addr_in = rd_en ? rd_addr : rd_addr_ff;
      root_in    = csr_write ? pwdata[VW-1:0] : root_ff;

      item_index_in = accept_write ? req_node_index   : item_index_ff;
      item_leaf_in  = accept_write ? req_node_is_leaf : item_leaf_ff;
      item_left_in  = accept_write ? req_left_child   : item_left_ff;
      item_right_in = accept_write ? req_right_child  : item_right_ff;
      item_sym_in   = accept_write ? req_node_symbol  : item_sym_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htbd_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         at_root_ff    <= 1'b1;
         walk_node_ff  <= '0;
         rem_ff        <= '0;
         root_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         at_root_ff    <= at_root_in;
         walk_node_ff  <= walk_node_in;
         rem_ff        <= rem_in;
         root_ff       <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      pend_sym_ff   <= pend_sym_in;
      byte_ff       <= byte_in;
      eos_ff        <= eos_in;
      rd_addr_ff    <= rd_addr_in;
      item_index_ff <= item_index_in;
      item_leaf_ff  <= item_leaf_in;
      item_left_ff  <= item_left_in;
      item_right_ff <= item_right_in;
      item_sym_ff   <= item_sym_in;
   end

endmodule

>>> rtl/htbd_checker.sv
// ============================================================================
// htbd_checker
// Port-level checks for the tree-walk decoder, bound to the top level.
// ============================================================================
module htbd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_opcode,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [htbd_pkg::SYM_W-1:0] rsp_symbol,
   input logic                       rsp_last_of_run,
   input logic                       pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_symbol) && $stable(rsp_last_of_run))
      else $error("stalled item changed");

   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == htbd_pkg::OP_DECODE) |=> req_stall)
      else $error("decode item not followed by busy");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == htbd_pkg::OP_WRITE_NODE) |=>
         req_stall ##1 req_stall ##1 req_stall ##1 !req_stall)
      else $error("node write timing wrong");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall && pready)
      else $error("bad state after reset");

endmodule

bind huffman_tree_bit_decoder_core htbd_checker u_htbd_checker (.*);
